FILE: design/lcp_pkg.sv
package lcp_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);
  localparam int MAG_W         = 10;
  localparam int ACC_W         = 14;

  localparam logic [MAG_W-1:0] MAG_LIMIT       = MAG_W'(999);
  localparam logic [7:0]       MAX_ANGLE_RESET = 8'd180;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FORMAT    = 3'd2,
    ST_TELEMETRY = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [9:0] {
    PH_LETTER  = 10'b00_0000_0001,
    PH_COMMA1  = 10'b00_0000_0010,
    PH_PAN_WS  = 10'b00_0000_0100,
    PH_PAN_SGN = 10'b00_0000_1000,
    PH_PAN_DIG = 10'b00_0001_0000,
    PH_COMMA2  = 10'b00_0010_0000,
    PH_TLT_WS  = 10'b00_0100_0000,
    PH_TLT_SGN = 10'b00_1000_0000,
    PH_TLT_DIG = 10'b01_0000_0000,
    PH_FAIL    = 10'b10_0000_0000
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // v*10 + digit, saturated
  function automatic logic [MAG_W-1:0] accumulate(input logic [MAG_W-1:0] v,
                                                  input logic [7:0] c);
    logic [ACC_W-1:0] n;
    n = ACC_W'(v) * ACC_W'(10) + ACC_W'(c[3:0]);
    return (n > ACC_W'(MAG_LIMIT)) ? MAG_LIMIT : n[MAG_W-1:0];
  endfunction

  function automatic logic angle_ok(input logic [MAG_W-1:0] mag, input logic neg,
                                    input logic [7:0] max_angle);
    return !(neg && mag != '0) && (mag <= MAG_W'(max_angle));
  endfunction

endpackage

FILE: design/line_command_parser_core.sv
// path: an accepted byte waits in the input register; its result is then registered in the
//   output register, once that register is free or its result is taken
// throughput: one byte per cycle; the input register keeps taking a byte while a
//   result waits, and stalls only when both registers are full and the result is held
// reset (rst_n low, synchronous): line state cleared, parser back to expecting 'C',
//   max_angle back to 180, input and output registers empty
module line_command_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_pan_angle,
  output logic [7:0] out_tilt_angle
);
  import lcp_pkg::*;

  logic [7:0]       max_angle_r;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0] vis_len_r, vis_len_nxt;
  logic [7:0]       first_char_r, first_char_nxt;
  phase_t           phase_r, phase_nxt;
  logic [MAG_W-1:0] pan_r, pan_nxt;
  logic [MAG_W-1:0] tilt_r, tilt_nxt;
  logic [1:0]       sign_r, sign_nxt;
  logic             zero_seen_r, zero_seen_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [7:0]       out_pan_r, out_tilt_r;

  logic             out_free, fire, in_accept;
  logic             res_valid;
  status_t          res_status;
  logic [7:0]       res_pan, res_tilt;
  logic [7:0]       c;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign c         = s1_byte_r;

  always_comb begin
    byte_count_nxt = byte_count_r;
    vis_len_nxt    = vis_len_r;
    first_char_nxt = first_char_r;
    phase_nxt      = phase_r;
    pan_nxt        = pan_r;
    tilt_nxt       = tilt_r;
    sign_nxt       = sign_r;
    zero_seen_nxt  = zero_seen_r;
    res_valid      = 1'b0;
    res_status     = ST_UNKNOWN;
    res_pan        = '0;
    res_tilt       = '0;

    if (c == CH_LF || c == CH_CR) begin
      if (byte_count_r != '0) begin
        if (vis_len_r >= CNT_W'(2)) begin
          res_valid = 1'b1;
          if (first_char_r == CH_C) begin
            if (phase_r == PH_TLT_DIG) begin
              if (angle_ok(pan_r, sign_r[0], max_angle_r) &&
                  angle_ok(tilt_r, sign_r[1], max_angle_r)) begin
                res_status = ST_ACCEPTED;
                res_pan    = pan_r[7:0];
                res_tilt   = tilt_r[7:0];
              end else begin
                res_status = ST_RANGE;
              end
            end else begin
              res_status = ST_FORMAT;
            end
          end else if (first_char_r == CH_T) begin
            res_status = ST_TELEMETRY;
          end
        end
        byte_count_nxt = '0;
        vis_len_nxt    = '0;
        first_char_nxt = '0;
        phase_nxt      = PH_LETTER;
        pan_nxt        = '0;
        tilt_nxt       = '0;
        sign_nxt       = '0;
        zero_seen_nxt  = 1'b0;
      end
    end else if (byte_count_r == CNT_W'(LINE_CAPACITY - 1)) begin
      // buffer full: drop the byte and restart the line
      res_valid      = 1'b1;
      res_status     = ST_OVERFLOW;
      byte_count_nxt = '0;
      vis_len_nxt    = '0;
      first_char_nxt = '0;
      phase_nxt      = PH_LETTER;
      pan_nxt        = '0;
      tilt_nxt       = '0;
      sign_nxt       = '0;
      zero_seen_nxt  = 1'b0;
    end else begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
      if (!zero_seen_r) begin
        if (c == CH_NUL) begin
          zero_seen_nxt = 1'b1;
        end else begin
          if (vis_len_r == '0) first_char_nxt = c;
          vis_len_nxt = vis_len_r + CNT_W'(1);
          unique case (phase_r) inside
            PH_LETTER: phase_nxt = (c == CH_C) ? PH_COMMA1 : PH_FAIL;
            PH_COMMA1: phase_nxt = (c == CH_COMMA) ? PH_PAN_WS : PH_FAIL;
            PH_PAN_WS, PH_PAN_SGN: begin
              if (phase_r == PH_PAN_WS && is_blank(c)) begin
                phase_nxt = PH_PAN_WS;
              end else if (phase_r == PH_PAN_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                if (c == CH_MINUS) sign_nxt[0] = 1'b1;
                phase_nxt = PH_PAN_SGN;
              end else if (is_digit(c)) begin
                pan_nxt   = accumulate(pan_r, c);
                phase_nxt = PH_PAN_DIG;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_PAN_DIG: begin
              if (is_digit(c)) pan_nxt = accumulate(pan_r, c);
              else phase_nxt = (c == CH_COMMA) ? PH_TLT_WS : PH_FAIL;
            end
            PH_COMMA2: phase_nxt = (c == CH_COMMA) ? PH_TLT_WS : PH_FAIL;
            PH_TLT_WS, PH_TLT_SGN: begin
              if (phase_r == PH_TLT_WS && is_blank(c)) begin
                phase_nxt = PH_TLT_WS;
              end else if (phase_r == PH_TLT_WS && (c == CH_PLUS || c == CH_MINUS)) begin
                if (c == CH_MINUS) sign_nxt[1] = 1'b1;
                phase_nxt = PH_TLT_SGN;
              end else if (is_digit(c)) begin
                tilt_nxt  = accumulate(tilt_r, c);
                phase_nxt = PH_TLT_DIG;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            // trailing text after the tilt number is ignored
            PH_TLT_DIG: if (is_digit(c)) tilt_nxt = accumulate(tilt_r, c);
            default:    phase_nxt = PH_FAIL;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_angle_r  <= MAX_ANGLE_RESET;
      s1_valid_r   <= 1'b0;
      byte_count_r <= '0;
      vis_len_r    <= '0;
      first_char_r <= '0;
      phase_r      <= PH_LETTER;
      pan_r        <= '0;
      tilt_r       <= '0;
      sign_r       <= '0;
      zero_seen_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) max_angle_r <= cfg_wr_data;
      if (in_accept) s1_valid_r <= 1'b1;
      else if (fire) s1_valid_r <= 1'b0;
      if (fire) begin
        byte_count_r <= byte_count_nxt;
        vis_len_r    <= vis_len_nxt;
        first_char_r <= first_char_nxt;
        phase_r      <= phase_nxt;
        pan_r        <= pan_nxt;
        tilt_r       <= tilt_nxt;
        sign_r       <= sign_nxt;
        zero_seen_r  <= zero_seen_nxt;
        out_valid_r  <= res_valid;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_byte_r <= in_rx_byte;
    if (fire && res_valid) begin
      out_status_r <= res_status;
      out_pan_r    <= res_pan;
      out_tilt_r   <= res_tilt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pan_angle  = out_pan_r;
  assign out_tilt_angle = out_tilt_r;

  // angles only leave the block with an accepted command
  a_angles_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_ACCEPTED |-> out_pan_r == '0 && out_tilt_r == '0)
    else $error("angles nonzero on a non-accepted result");

  // a zero byte is always counted in the line
  a_zero_counted: assert property (@(posedge clk) disable iff (!rst_n)
    zero_seen_r |-> byte_count_r != '0)
    else $error("zero byte seen on an empty line");

  // visible length never runs past the stored byte count
  a_vis_len: assert property (@(posedge clk) disable iff (!rst_n)
    vis_len_r <= byte_count_r)
    else $error("visible length exceeds byte count");

  // the input register only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a pending result");

endmodule

FILE: tb/sv/line_command_parser_core_tb.sv
`timescale 1ns / 1ps

import lcp_pkg::*;

typedef struct packed {
  status_t    status;
  logic [7:0] pan;
  logic [7:0] tilt;
} line_result_t;

class parse_scoreboard;
  logic [7:0]   max_angle;
  int           errors;
  line_result_t line_results_q[$];

  // running line state, kept at the block's widths
  logic [CNT_W-1:0] stored;
  logic [CNT_W-1:0] vis_len;
  logic [7:0] first_char;
  phase_t     phase;
  logic [9:0] pan_mag;
  logic [9:0] tilt_mag;
  logic [1:0] neg;
  bit         nul_seen;

  function new();
    max_angle = MAX_ANGLE_RESET;
    errors = 0;
    clear_line();
  endfunction

  function void clear_line();
    stored = '0;
    vis_len = '0;
    first_char = '0;
    phase = PH_LETTER;
    pan_mag = '0;
    tilt_mag = '0;
    neg = '0;
    nul_seen = 1'b0;
  endfunction

  function bit is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function bit is_num(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function logic [9:0] mac10(logic [9:0] v, logic [7:0] c);
    int n;
    n = int'(v) * 10 + int'(c) - int'(CH_ZERO);
    return (n > int'(MAG_LIMIT)) ? MAG_LIMIT : 10'(n);
  endfunction

  function bit in_range(logic [9:0] mag, bit minus);
    if (minus && mag != '0) return 1'b0;
    return mag <= {2'b00, max_angle};
  endfunction

  function void step_parser(logic [7:0] c);
    case (phase)
      PH_LETTER: phase = (c == CH_C) ? PH_COMMA1 : PH_FAIL;
      PH_COMMA1: phase = (c == CH_COMMA) ? PH_PAN_WS : PH_FAIL;
      PH_PAN_WS: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          if (c == CH_MINUS) neg[0] = 1'b1;
          phase = PH_PAN_SGN;
        end else if (is_num(c)) begin
          pan_mag = mac10(pan_mag, c);
          phase = PH_PAN_DIG;
        end else if (!is_space(c)) begin
          phase = PH_FAIL;
        end
      end
      PH_PAN_SGN: begin
        if (is_num(c)) begin
          pan_mag = mac10(pan_mag, c);
          phase = PH_PAN_DIG;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_PAN_DIG: begin
        if (is_num(c)) pan_mag = mac10(pan_mag, c);
        else phase = (c == CH_COMMA) ? PH_TLT_WS : PH_FAIL;
      end
      PH_COMMA2: phase = (c == CH_COMMA) ? PH_TLT_WS : PH_FAIL;
      PH_TLT_WS: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          if (c == CH_MINUS) neg[1] = 1'b1;
          phase = PH_TLT_SGN;
        end else if (is_num(c)) begin
          tilt_mag = mac10(tilt_mag, c);
          phase = PH_TLT_DIG;
        end else if (!is_space(c)) begin
          phase = PH_FAIL;
        end
      end
      PH_TLT_SGN: begin
        if (is_num(c)) begin
          tilt_mag = mac10(tilt_mag, c);
          phase = PH_TLT_DIG;
        end else begin
          phase = PH_FAIL;
        end
      end
      // trailing text after the tilt number is ignored
      PH_TLT_DIG: if (is_num(c)) tilt_mag = mac10(tilt_mag, c);
      default: phase = PH_FAIL;
    endcase
  endfunction

  // one accepted request byte; queues the line status it completes, if any
  function void take_byte(logic [7:0] c);
    line_result_t r;
    r = '{status: ST_ACCEPTED, pan: 8'd0, tilt: 8'd0};
    if (c == CH_LF || c == CH_CR) begin
      if (stored != '0) begin
        if (vis_len >= CNT_W'(2)) begin
          if (first_char == CH_C) begin
            if (phase != PH_TLT_DIG) begin
              r.status = ST_FORMAT;
            end else if (in_range(pan_mag, neg[0]) && in_range(tilt_mag, neg[1])) begin
              r.status = ST_ACCEPTED;
              r.pan = pan_mag[7:0];
              r.tilt = tilt_mag[7:0];
            end else begin
              r.status = ST_RANGE;
            end
          end else if (first_char == CH_T) begin
            r.status = ST_TELEMETRY;
          end else begin
            r.status = ST_UNKNOWN;
          end
          line_results_q.push_back(r);
        end
        clear_line();
      end
    end else if (stored >= CNT_W'(LINE_CAPACITY - 1)) begin
      // full line: byte dropped, line restarts
      r.status = ST_OVERFLOW;
      line_results_q.push_back(r);
      clear_line();
    end else begin
      if (!nul_seen) begin
        if (c == CH_NUL) begin
          nul_seen = 1'b1;
        end else begin
          if (vis_len == '0) first_char = c;
          vis_len++;
          step_parser(c);
        end
      end
      stored++;
    end
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(status_t status, logic [7:0] pan, logic [7:0] tilt);
    line_result_t exp_r;
    if (line_results_q.size() == 0) begin
      report($sformatf("unexpected result status=%0d pan=%0d tilt=%0d", status, pan, tilt));
    end else begin
      exp_r = line_results_q.pop_front();
      if (status !== exp_r.status)
        report($sformatf("status got %0d want %0d", status, exp_r.status));
      if (pan !== exp_r.pan)
        report($sformatf("pan_angle got %0d want %0d", pan, exp_r.pan));
      if (tilt !== exp_r.tilt)
        report($sformatf("tilt_angle got %0d want %0d", tilt, exp_r.tilt));
    end
  endtask

  task check_drained();
    if (line_results_q.size() != 0)
      report($sformatf("%0d results never arrived", line_results_q.size()));
  endtask

  function int pending();
    return line_results_q.size();
  endfunction
endclass

module line_command_parser_core_tb;

  localparam int LATENCY          = 2;
  localparam int HOLD_CYCLES      = 200;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int CYCLE_LIMIT      = 600000;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_pan_angle;
  logic [7:0] out_tilt_angle;

  parse_scoreboard sb;
  logic [7:0]      line_bytes[$];
  bit              quiet = 1'b0;
  bit              hold_req = 1'b0;
  bit              hold_taken = 1'b0;
  int unsigned     cycles = 0;

  line_command_parser_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_pan_angle (out_pan_angle),
    .out_tilt_angle(out_tilt_angle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_byte(in_rx_byte);
      if (out_valid && !out_stall)
        sb.check_result(status_t'(out_status), out_pan_angle, out_tilt_angle);
    end
  end

  // result side back-pressure
  initial begin : receiver
    int dur;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        dur = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (dur) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_max_angle(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.max_angle = v;
  endtask

  function automatic void push_byte(logic [7:0] b);
    line_bytes.push_back(b);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  // any byte except a line terminator
  function automatic logic [7:0] body_byte(int lo);
    logic [7:0] b;
    b = 8'($urandom_range(lo, 255));
    if (b == CH_LF || b == CH_CR) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic void push_printable(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(32, 126)));
  endfunction

  function automatic void push_blanks();
    int n;
    n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: push_byte(CH_SPACE);
        1: push_byte(CH_TAB);
        2: push_byte(CH_VT);
        default: push_byte(CH_FF);
      endcase
    end
  endfunction

  function automatic int pick_mag();
    int lim;
    lim = int'(sb.max_angle);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return lim;
      2: return lim + 1;
      3: return (lim > 0) ? lim - 1 : 0;
      4, 5: return $urandom_range(0, lim);
      6: return $urandom_range(0, 999);
      7: return $urandom_range(1000, 99999);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void push_number();
    int r;
    push_blanks();
    r = $urandom_range(0, 19);
    if (r < 3) push_byte(CH_PLUS);
    else if (r < 8) push_byte(CH_MINUS);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
    push_text($sformatf("%0d", pick_mag()));
  endfunction

  function automatic void push_end();
    case ($urandom_range(0, 9))
      0: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      1, 2, 3, 4: push_byte(CH_CR);
      default: push_byte(CH_LF);
    endcase
  endfunction

  function automatic void push_command();
    push_byte(CH_C);
    push_byte(CH_COMMA);
    push_number();
    push_byte(CH_COMMA);
    push_number();
    if ($urandom_range(0, 3) == 0) push_printable($urandom_range(1, 3));
  endfunction

  function automatic void build_random_line();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    line_bytes.delete();
    if (r < 45) begin
      push_command();
      push_end();
    end else if (r < 60) begin
      // broken command: one byte replaced, dropped or inserted
      push_command();
      idx = $urandom_range(0, line_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: line_bytes[idx] = 8'($urandom_range(0, 255));
        1: line_bytes.delete(idx);
        default: line_bytes.insert(idx, 8'($urandom_range(0, 255)));
      endcase
      push_end();
    end else if (r < 68) begin
      push_byte(CH_T);
      push_printable($urandom_range(1, 8));
      push_end();
    end else if (r < 74) begin
      idx = ($urandom_range(0, 1) == 0) ? $urandom_range(33, 126) : $urandom_range(128, 255);
      if (8'(idx) == CH_C || 8'(idx) == CH_T) idx = idx + 1;
      push_byte(8'(idx));
      push_printable($urandom_range(1, 8));
      push_end();
    end else if (r < 79) begin
      // lines with fewer than two visible characters
      case ($urandom_range(0, 2))
        0: push_byte(body_byte(1));
        1: begin
          push_byte(CH_NUL);
          push_printable($urandom_range(0, 4));
        end
        default: begin
          push_byte(body_byte(1));
          push_byte(CH_NUL);
          push_printable($urandom_range(0, 4));
        end
      endcase
      push_end();
    end else if (r < 85) begin
      push_command();
      line_bytes.insert($urandom_range(0, line_bytes.size()), CH_NUL);
      push_end();
    end else if (r < 89) begin
      // around the buffer limit
      push_byte(($urandom_range(0, 1) == 0) ? CH_C : 8'($urandom_range(32, 126)));
      push_printable($urandom_range(LINE_CAPACITY - 5, LINE_CAPACITY + 35));
      push_end();
    end else begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_random_line();
      sent += line_bytes.size();
      send_line();
    end
  endtask

  task automatic run_directed();
    push_byte(CH_LF);                        // terminator on an empty line
    push_text("C,-0,180");                   // negative zero, angle at the limit
    push_byte(CH_CR);
    push_text("T1");
    push_byte(CH_LF);
    push_text("?!");
    push_byte(CH_LF);
    push_text("Q");                          // too short for a status
    push_byte(CH_LF);
    push_text("C,");                         // zero byte hides the rest
    push_byte(CH_NUL);
    push_text("5");
    push_byte(CH_LF);
    push_text("C,1234,7");                   // saturates at 999
    push_byte(CH_CR);
    send_line();
  endtask

  // receiver holds off while the sender keeps offering short lines
  task automatic fill_and_block();
    quiet = 1'b1;
    hold_req = 1'b1;
    // start sending only once the long hold is under way
    while (!hold_taken) @(posedge clk);
    repeat (12) begin
      push_byte(CH_T);
      push_byte(8'($urandom_range(48, 57)));
      push_byte(CH_LF);
      send_line();
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] angles [6];
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    angles[0] = 8'd0;
    angles[1] = 8'd255;
    angles[2] = MAX_ANGLE_RESET;
    angles[3] = 8'($urandom_range(1, 254));
    angles[4] = 8'd1;
    angles[5] = 8'd90;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_max_angle(angles[p]);
      quiet = (p == 2);
      if (p == 3) fill_and_block();
      run_random(RANDOM_PER_PHASE);
    end
    quiet = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
